[rtl/ael_pkg.sv]
// shared constants, token types and fraction weight table for the expression lexer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package ael_pkg;

	// fixed point format of a literal
	localparam int INT_BITS    = 32;
	localparam int FRAC_BITS   = 16;
	localparam int FRAC_DIGITS = 5;

	localparam int VAL_W   = INT_BITS + FRAC_BITS;
	localparam int FRAC_W  = FRAC_BITS + 1;
	localparam int POS_W   = $clog2(FRAC_DIGITS + 1);
	localparam int IMAC_W  = INT_BITS + 4;

	// field widths of the channels
	localparam int CH_W    = 8;
	localparam int KIND_W  = 2;
	localparam int OP_W    = 2;
	localparam int VALUE_W = 48;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_OP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LIT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNK = 2'd3;

	// operator codes
	localparam logic [OP_W-1:0] OP_PLUS  = 2'd0;
	localparam logic [OP_W-1:0] OP_MINUS = 2'd1;
	localparam logic [OP_W-1:0] OP_STAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_SLASH = 2'd3;

	// characters of interest
	localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
	localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
	localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CH_W-1:0] CH_POINT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;

	localparam logic [3:0] DEC_BASE = 4'd10;

	// powers of ten for the weight table
	localparam logic [63:0] P10_1 = 64'd10;
	localparam logic [63:0] P10_2 = 64'd100;
	localparam logic [63:0] P10_3 = 64'd1000;
	localparam logic [63:0] P10_4 = 64'd10000;
	localparam logic [63:0] P10_5 = 64'd100000;
	localparam logic [63:0] P10_6 = 64'd1000000;
	localparam logic [63:0] P10_7 = 64'd10000000;
	localparam logic [63:0] P10_8 = 64'd100000000;
	localparam logic [63:0] P10_9 = 64'd1000000000;

	// weights indexed [digit][position]; position 0 is unused
	typedef logic [9:0][FRAC_DIGITS:0][FRAC_BITS-1:0] weight_tbl_t;

	// round(d * 2^FRAC_BITS / 10^p), evaluated at elaboration only
	function automatic weight_tbl_t build_weights();
		weight_tbl_t t;
		logic [63:0] num;
		logic [63:0] w;
		t = '0;
		for (int d = 0; d < 10; d++) begin
			for (int p = 1; p <= FRAC_DIGITS; p++) begin
				num = 64'(d) << FRAC_BITS;
				case (p)
					1: w = (num + P10_1 / 2) / P10_1;
					2: w = (num + P10_2 / 2) / P10_2;
					3: w = (num + P10_3 / 2) / P10_3;
					4: w = (num + P10_4 / 2) / P10_4;
					5: w = (num + P10_5 / 2) / P10_5;
					6: w = (num + P10_6 / 2) / P10_6;
					7: w = (num + P10_7 / 2) / P10_7;
					8: w = (num + P10_8 / 2) / P10_8;
					9: w = (num + P10_9 / 2) / P10_9;
					default: w = '0;
				endcase
				t[d][p] = FRAC_BITS'(w);
			end
		end
		return t;
	endfunction

	localparam weight_tbl_t WEIGHTS = build_weights();

	// one output token
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [OP_W-1:0]    op_code;
		logic [VALUE_W-1:0] value;
		logic               overflow;
		logic               last_of_run;
	} tok_t;

endpackage

`default_nettype wire

[rtl/ael_chars_if.sv]
// valid/ready channel carrying one character word into the lexer
// depends on ael_pkg for field widths
`default_nettype none

interface ael_chars_if;
	import ael_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;
	logic            end_of_string;

	modport source (output valid, output ch, output end_of_string, input ready);
	modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

`default_nettype wire

[rtl/ael_tokens_if.sv]
// valid/ready channel carrying one token word out of the lexer
// depends on ael_pkg for field widths
`default_nettype none

interface ael_tokens_if;
	import ael_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [OP_W-1:0]    op_code;
	logic [VALUE_W-1:0] value;
	logic               overflow;
	logic               last_of_run;

	modport source (output valid, output kind, output op_code, output value,
		output overflow, output last_of_run, input ready);
	modport sink   (input valid, input kind, input op_code, input value,
		input overflow, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/arithmetic_expression_lexer.sv]
// top level of the streaming arithmetic expression lexer
// depends on ael_pkg, ael_chars_if and ael_tokens_if
`default_nettype none

// Streaming lexer: one ASCII character word enters on chars per cycle and
// tokens leave on tokens. Operators + - * / give operator tokens, a newline
// outside a number gives an end token, spaces are skipped and any other
// stray character gives a one-character unknown token. A digit opens a
// literal that runs until a space, an operator or end_of_string; its value
// is unsigned fixed point (INT_BITS.FRAC_BITS, zero-extended to 48 bits),
// the integer part saturates with overflow set, and fraction digits past
// FRAC_DIGITS are ignored. Each character is decoded in the cycle it is
// accepted, so a character is taken every cycle while tokens drains. A
// character that closes a literal with an operator yields two tokens
// (literal, then operator); the second sits in a one-entry overflow slot
// and holds chars.ready low until the literal is taken. last_of_run marks
// the final token of each character. There is no configuration and no
// clearing after reset.

module arithmetic_expression_lexer (
	input  wire          clk,
	input  wire          arst_n,
	ael_chars_if.sink    chars,
	ael_tokens_if.source tokens
);
	import ael_pkg::*;

	// lexer state
	logic                in_number_q;
	logic                in_fraction_q;
	logic [INT_BITS-1:0] integer_q;
	logic [FRAC_W-1:0]   fraction_q;
	logic [POS_W-1:0]    position_q;
	logic                saturated_q;

	// output register and overflow slot for the second token
	tok_t out_q;
	logic out_valid_q;
	tok_t pend_q;
	logic pend_valid_q;

	logic take;
	logic acc;

	// character decode
	logic            is_digit;
	logic            is_op;
	logic [OP_W-1:0] op_sel;
	logic [3:0]      digit;

	// state after absorbing the character into a literal
	logic                abs_in_fraction;
	logic [INT_BITS-1:0] abs_integer;
	logic [FRAC_W-1:0]   abs_fraction;
	logic [POS_W-1:0]    abs_position;
	logic                abs_saturated;
	logic [IMAC_W-1:0]   int_mac;
	logic [POS_W-1:0]    pos_next;

	// results of this character
	tok_t       r0;
	tok_t       r1;
	logic [1:0] n_res;

	logic                nx_in_number;
	logic                nx_in_fraction;
	logic [INT_BITS-1:0] nx_integer;
	logic [FRAC_W-1:0]   nx_fraction;
	logic [POS_W-1:0]    nx_position;
	logic                nx_saturated;

	// build a literal token; the rounded fraction may carry past the top
	function automatic tok_t make_literal(logic [INT_BITS-1:0] ip,
		logic [FRAC_W-1:0] fp, logic sat);
		tok_t             t;
		logic [VAL_W:0]   sum;
		logic [VAL_W-1:0] total;
		sum = {1'b0, ip, {FRAC_BITS{1'b0}}} + (VAL_W + 1)'(fp);
		if (sum[VAL_W]) begin
			total = '1;
		end else begin
			total = sum[VAL_W-1:0];
		end
		t.kind        = KIND_LIT;
		t.op_code     = OP_PLUS;
		t.value       = VALUE_W'(total);
		t.overflow    = sat | sum[VAL_W];
		t.last_of_run = 1'b0;
		return t;
	endfunction

	function automatic tok_t make_simple(logic [KIND_W-1:0] k, logic [OP_W-1:0] op);
		tok_t t;
		t.kind        = k;
		t.op_code     = op;
		t.value       = '0;
		t.overflow    = 1'b0;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	// one character per cycle unless the overflow slot is busy or tokens stalls a held token
	assign take        = out_valid_q && tokens.ready;
	assign chars.ready = !pend_valid_q && (!out_valid_q || tokens.ready);
	assign acc         = chars.valid && chars.ready;

	always_comb begin
		is_digit = chars.ch inside {[CH_ZERO:CH_NINE]};
		digit    = is_digit ? 4'(chars.ch - CH_ZERO) : 4'd0;
		is_op    = 1'b1;
		case (chars.ch)
			CH_PLUS:  op_sel = OP_PLUS;
			CH_MINUS: op_sel = OP_MINUS;
			CH_STAR:  op_sel = OP_STAR;
			CH_SLASH: op_sel = OP_SLASH;
			default: begin
				op_sel = OP_PLUS;
				is_op  = 1'b0;
			end
		endcase
	end

	// absorb: integer digits multiply-accumulate, fraction digits add a weight
	always_comb begin
		int_mac  = {4'd0, integer_q} * DEC_BASE + IMAC_W'(digit);
		pos_next = position_q + 1'b1;

		abs_in_fraction = in_fraction_q;
		abs_integer     = integer_q;
		abs_fraction    = fraction_q;
		abs_position    = position_q;
		abs_saturated   = saturated_q;

		if (!in_fraction_q) begin
			if (is_digit) begin
				if (|int_mac[IMAC_W-1:INT_BITS]) begin
					abs_integer   = '1;
					abs_saturated = 1'b1;
				end else begin
					abs_integer = int_mac[INT_BITS-1:0];
				end
			end else if (chars.ch == CH_POINT) begin
				abs_in_fraction = 1'b1;
			end
		end else if (position_q < POS_W'(FRAC_DIGITS)) begin
			// every character past the point uses up a position
			abs_position = pos_next;
			if (is_digit) begin
				abs_fraction = fraction_q + FRAC_W'(WEIGHTS[digit][pos_next]);
			end
		end
	end

	// token selection and next state
	always_comb begin
		r0    = make_simple(KIND_UNK, OP_PLUS);
		r1    = make_simple(KIND_OP, op_sel);
		n_res = 2'd0;

		nx_in_number   = in_number_q;
		nx_in_fraction = in_fraction_q;
		nx_integer     = integer_q;
		nx_fraction    = fraction_q;
		nx_position    = position_q;
		nx_saturated   = saturated_q;

		if (in_number_q && (chars.ch == CH_SPACE || is_op)) begin
			// literal closes on the state before this character
			r0           = make_literal(integer_q, fraction_q, saturated_q);
			n_res        = is_op ? 2'd2 : 2'd1;
			nx_in_number = 1'b0;
		end else if (in_number_q || is_digit) begin
			nx_in_number   = 1'b1;
			nx_in_fraction = abs_in_fraction;
			nx_integer     = abs_integer;
			nx_fraction    = abs_fraction;
			nx_position    = abs_position;
			nx_saturated   = abs_saturated;
			if (chars.end_of_string) begin
				r0    = make_literal(abs_integer, abs_fraction, abs_saturated);
				n_res = 2'd1;
			end
		end else if (is_op) begin
			r0    = make_simple(KIND_OP, op_sel);
			n_res = 2'd1;
		end else if (chars.ch == CH_NEWLINE) begin
			r0    = make_simple(KIND_END, OP_PLUS);
			n_res = 2'd1;
		end else if (chars.ch != CH_SPACE) begin
			r0    = make_simple(KIND_UNK, OP_PLUS);
			n_res = 2'd1;
		end

		// end of string or a closed literal returns to idle
		if (chars.end_of_string || !nx_in_number) begin
			nx_in_number   = 1'b0;
			nx_in_fraction = 1'b0;
			nx_integer     = '0;
			nx_fraction    = '0;
			nx_position    = '0;
			nx_saturated   = 1'b0;
		end

		r0.last_of_run = (n_res == 2'd1);
		r1.last_of_run = 1'b1;
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_number_q   <= 1'b0;
			in_fraction_q <= 1'b0;
			integer_q     <= '0;
			fraction_q    <= '0;
			position_q    <= '0;
			saturated_q   <= 1'b0;
		end else if (acc) begin
			in_number_q   <= nx_in_number;
			in_fraction_q <= nx_in_fraction;
			integer_q     <= nx_integer;
			fraction_q    <= nx_fraction;
			position_q    <= nx_position;
			saturated_q   <= nx_saturated;
		end
	end

	// output valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (acc) begin
			if (n_res != 2'd0) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			pend_valid_q <= (n_res == 2'd2);
		end else if (take) begin
			// the waiting second token moves up, else the output empties
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			if (n_res != 2'd0) begin
				out_q <= r0;
			end
			if (n_res == 2'd2) begin
				pend_q <= r1;
			end
		end else if (take && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.kind        = out_q.kind;
	assign tokens.op_code     = out_q.op_code;
	assign tokens.value       = out_q.value;
	assign tokens.overflow    = out_q.overflow;
	assign tokens.last_of_run = out_q.last_of_run;

	// the overflow slot only holds a token while the output register holds one too
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second token waiting with empty output register");

	// a two-token run is always literal then operator, marked last only on the operator
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (out_q.kind == KIND_LIT && !out_q.last_of_run
			&& pend_q.kind == KIND_OP && pend_q.last_of_run))
		else $error("malformed two-token run");

	// outside a literal the accumulators are clear
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_number_q |-> (integer_q == '0 && fraction_q == '0 && position_q == '0
			&& !saturated_q && !in_fraction_q))
		else $error("literal state left over outside a number");

	// end of string always returns the lexer to idle
	a_eos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.end_of_string) |=> !in_number_q)
		else $error("literal still open after end of string");

	// a saturated integer part sticks at all ones
	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		saturated_q |-> (integer_q == '1))
		else $error("saturated integer part is not all ones");

endmodule

`default_nettype wire
